@@ rtl/core/bqf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared widths, coefficient slot codes, transfer types and saturation
// helpers for the cascaded biquad filter.
// ----------------------------------------------------------------------------
package bqf_pkg;

   localparam int MAX_SECTIONS = 8;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEF_WIDTH   = 20;
   localparam int FRAC_BITS    = 16;
   localparam int DELAY_WIDTH  = 40;
   localparam int SLOTS        = 5;

   localparam int SECT_W      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int SLOT_W      = 3;
   localparam int COUNT_W     = 4;
   localparam int COEF_DEPTH  = MAX_SECTIONS * SLOTS;
   localparam int COEF_ADDR_W = $clog2(COEF_DEPTH);
   localparam int PROD_WIDTH  = COEF_WIDTH + SAMPLE_WIDTH;
   localparam int ACC_WIDTH   = ((PROD_WIDTH > DELAY_WIDTH) ? PROD_WIDTH : DELAY_WIDTH) + 2;

   localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   typedef struct packed {
      logic              start;
      logic [SECT_W-1:0] last_sect;
   } bqf_start_type;

   typedef struct packed {
      logic                           valid;
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           clip;
   } bqf_result_type;

   typedef struct packed {
      logic signed [DELAY_WIDTH-1:0] d1;
      logic signed [DELAY_WIDTH-1:0] d2;
   } bqf_delay_pair_type;

   typedef struct packed {
      logic               rd_en;
      logic [SECT_W-1:0]  rd_addr;
      logic               wr_en;
      logic [SECT_W-1:0]  wr_addr;
      bqf_delay_pair_type wr_data;
   } bqf_dly_req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           clip;
   } bqf_sat_type;

   function automatic logic [COEF_ADDR_W-1:0] coef_addr(input logic [SECT_W-1:0] sect,
                                                       input logic [SLOT_W-1:0] slot);
      return COEF_ADDR_W'(int'(sect) * SLOTS + int'(slot));
   endfunction

   // clamp to the signed delay range
   function automatic logic signed [DELAY_WIDTH-1:0] sat_delay(
         input logic signed [ACC_WIDTH-1:0] v);
      logic [ACC_WIDTH-DELAY_WIDTH:0] top;
      top = v[ACC_WIDTH-1:DELAY_WIDTH-1];
      if ((&top) || !(|top)) begin
         return v[DELAY_WIDTH-1:0];
      end else if (v[ACC_WIDTH-1]) begin
         return {1'b1, {(DELAY_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(DELAY_WIDTH-1){1'b1}}};
      end
   endfunction

   // clamp to the signed sample range and flag the clamp
   function automatic bqf_sat_type sat_sample(input logic signed [ACC_WIDTH-1:0] v);
      logic [ACC_WIDTH-SAMPLE_WIDTH:0] top;
      bqf_sat_type                     res;
      top = v[ACC_WIDTH-1:SAMPLE_WIDTH-1];
      if ((&top) || !(|top)) begin
         res.sample = v[SAMPLE_WIDTH-1:0];
         res.clip   = 1'b0;
      end else if (v[ACC_WIDTH-1]) begin
         res.sample = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
         res.clip   = 1'b1;
      end else begin
         res.sample = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
         res.clip   = 1'b1;
      end
      return res;
   endfunction

endpackage

@@ rtl/core/bqf_coef_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqf_coef_mem
// Coefficient store: one write port, one registered read port, and a valid
// bit per entry so that unwritten coefficients read as zero after reset.
// ----------------------------------------------------------------------------
module bqf_coef_mem (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [bqf_pkg::COEF_ADDR_W-1:0]      wr_addr,
   input  logic signed [bqf_pkg::COEF_WIDTH-1:0] wr_data,
   input  logic [bqf_pkg::COEF_ADDR_W-1:0]      rd_addr,
   output logic signed [bqf_pkg::COEF_WIDTH-1:0] rd_data
);

   logic signed [bqf_pkg::COEF_WIDTH-1:0] mem [bqf_pkg::COEF_DEPTH];
   logic [bqf_pkg::COEF_DEPTH-1:0]        valid_ff;
   logic signed [bqf_pkg::COEF_WIDTH-1:0] rd_data_ff;
   logic                                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ rtl/core/bqf_delay_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqf_delay_mem
// Delay store: one entry per section holding both transposed delays, with a
// registered read port and a valid bit per section for the zero reset state.
// ----------------------------------------------------------------------------
module bqf_delay_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  bqf_pkg::bqf_dly_req_type    req,
   output bqf_pkg::bqf_delay_pair_type rd_data
);

   bqf_pkg::bqf_delay_pair_type       mem [bqf_pkg::MAX_SECTIONS];
   logic [bqf_pkg::MAX_SECTIONS-1:0]  valid_ff;
   bqf_pkg::bqf_delay_pair_type       rd_data_ff;
   logic                              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            valid_ff[req.wr_addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_valid_ff <= valid_ff[req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ rtl/core/bqf_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqf_engine
// Section sequencer and shared multiply-accumulate datapath. Walks the active
// sections, reading coefficients and delays, and writes the delays back.
// ----------------------------------------------------------------------------
module bqf_engine (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bqf_pkg::bqf_start_type                 start,
   input  logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] start_sample,
   input  logic                                   out_free,
   output logic                                   idle,
   output bqf_pkg::bqf_result_type                result,
   output logic [bqf_pkg::COEF_ADDR_W-1:0]        coef_rd_addr,
   input  logic signed [bqf_pkg::COEF_WIDTH-1:0]  coef_rd_data,
   output bqf_pkg::bqf_dly_req_type               dly_req,
   input  bqf_pkg::bqf_delay_pair_type            dly_rd_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_B0,
      ST_Y,
      ST_A1,
      ST_B2,
      ST_A2,
      ST_D2,
      ST_FIN
   } state_type;

   localparam logic signed [bqf_pkg::ACC_WIDTH-1:0] HALF_LSB =
      bqf_pkg::ACC_WIDTH'(1) <<< (bqf_pkg::FRAC_BITS - 1);

   state_type                                state_ff, state_in;
   logic [bqf_pkg::SECT_W-1:0]               sect_ff, sect_in;
   logic [bqf_pkg::SECT_W-1:0]               last_ff, last_in;
   logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]  x_ff, x_in;
   logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]  y_ff, y_in;
   logic                                     clip_ff, clip_in;
   logic signed [bqf_pkg::PROD_WIDTH-1:0]    prod_ff, prod_in;
   logic signed [bqf_pkg::ACC_WIDTH-1:0]     acc_ff, acc_in;
   logic signed [bqf_pkg::DELAY_WIDTH-1:0]   d1n_ff, d1n_in;

   logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]  operand;
   logic signed [bqf_pkg::DELAY_WIDTH-1:0]   psat;
   logic signed [bqf_pkg::ACC_WIDTH-1:0]     y_sum;
   logic signed [bqf_pkg::ACC_WIDTH-1:0]     y_shift;
   bqf_pkg::bqf_sat_type                     y_sat;
   logic [bqf_pkg::SECT_W-1:0]               sect_next;
   logic                                     at_last;

   // product clamped to the delay range, from last cycle's multiply
   assign psat      = bqf_pkg::sat_delay(bqf_pkg::ACC_WIDTH'(prod_ff));
   assign y_sum     = bqf_pkg::ACC_WIDTH'(psat) + bqf_pkg::ACC_WIDTH'(dly_rd_data.d1) + HALF_LSB;
   assign y_shift   = y_sum >>> bqf_pkg::FRAC_BITS;
   assign y_sat     = bqf_pkg::sat_sample(y_shift);
   assign sect_next = bqf_pkg::SECT_W'(sect_ff + 1'b1);
   assign at_last   = (sect_ff == last_ff);

   assign prod_in = bqf_pkg::PROD_WIDTH'(coef_rd_data) * bqf_pkg::PROD_WIDTH'(operand);

   always_comb begin
      state_in      = state_ff;
      sect_in       = sect_ff;
      last_in       = last_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      clip_in       = clip_ff;
      acc_in        = acc_ff;
      d1n_in        = d1n_ff;
      operand       = x_ff;
      coef_rd_addr  = '0;
      dly_req       = '0;
      result.valid  = 1'b0;
      result.sample = x_ff;
      result.clip   = clip_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start.start) begin
               x_in            = start_sample;
               sect_in         = '0;
               last_in         = start.last_sect;
               clip_in         = 1'b0;
               dly_req.rd_en   = 1'b1;
               dly_req.rd_addr = '0;
               coef_rd_addr    = bqf_pkg::coef_addr('0, bqf_pkg::SLOT_B0);
               state_in        = ST_B0;
            end
         end
         ST_B0: begin
            operand      = x_ff;
            coef_rd_addr = bqf_pkg::coef_addr(sect_ff, bqf_pkg::SLOT_B1);
            state_in     = ST_Y;
         end
         ST_Y: begin
            operand      = x_ff;
            y_in         = y_sat.sample;
            clip_in      = clip_ff | y_sat.clip;
            coef_rd_addr = bqf_pkg::coef_addr(sect_ff, bqf_pkg::SLOT_A1);
            state_in     = ST_A1;
         end
         ST_A1: begin
            operand      = y_ff;
            acc_in       = bqf_pkg::ACC_WIDTH'(psat) + bqf_pkg::ACC_WIDTH'(dly_rd_data.d2);
            coef_rd_addr = bqf_pkg::coef_addr(sect_ff, bqf_pkg::SLOT_B2);
            state_in     = ST_B2;
         end
         ST_B2: begin
            operand      = x_ff;
            d1n_in       = bqf_pkg::sat_delay(acc_ff - bqf_pkg::ACC_WIDTH'(psat));
            coef_rd_addr = bqf_pkg::coef_addr(sect_ff, bqf_pkg::SLOT_A2);
            state_in     = ST_A2;
         end
         ST_A2: begin
            operand  = y_ff;
            acc_in   = bqf_pkg::ACC_WIDTH'(psat);
            state_in = ST_D2;
         end
         ST_D2: begin
            dly_req.wr_en      = 1'b1;
            dly_req.wr_addr    = sect_ff;
            dly_req.wr_data.d1 = d1n_ff;
            dly_req.wr_data.d2 = bqf_pkg::sat_delay(acc_ff - bqf_pkg::ACC_WIDTH'(psat));
            x_in               = y_ff;
            if (at_last) begin
               state_in = ST_FIN;
            end else begin
               // fetch the next section while this one writes back
               sect_in         = sect_next;
               dly_req.rd_en   = 1'b1;
               dly_req.rd_addr = sect_next;
               coef_rd_addr    = bqf_pkg::coef_addr(sect_next, bqf_pkg::SLOT_B0);
               state_in        = ST_B0;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               result.valid = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign idle = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sect_ff <= sect_in;
      last_ff <= last_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      clip_ff <= clip_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      d1n_ff  <= d1n_in;
   end

endmodule

@@ rtl/core/cascaded_biquad_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_biquad_filter
// Cascade of up to eight transposed direct form II biquad sections in fixed
// point, with a shared multiplier and memory-held coefficients and delays.
// ----------------------------------------------------------------------------
// A filter transaction walks each section in use (section_count, 0 treated
// as 1 and values above eight as eight) through states B0, Y, A1, B2, A2 and
// D2, then waits in FIN until the output register is free, and no further
// request is taken until it ends: each section needs five products through
// the one shared multiplier, with the coefficient store read one coefficient
// per cycle, and the delay write-back of a section overlaps the fetch of the
// next. A coefficient load returns nothing. The result sits in an output
// register, so the next request is taken while an earlier result still waits.
// Coefficients and delays are zero after reset without any clearing pass.
// ----------------------------------------------------------------------------
module cascaded_biquad_filter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_operation,
   input  logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] req_sample_in,
   input  logic [bqf_pkg::SECT_W-1:0]             req_coef_section,
   input  logic [bqf_pkg::SLOT_W-1:0]             req_coef_slot,
   input  logic signed [bqf_pkg::COEF_WIDTH-1:0]  req_coef_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                                   rsp_clipped,
   input  logic                                   csr_write_enable,
   input  logic [bqf_pkg::COUNT_W-1:0]            csr_write_data
);

   logic [bqf_pkg::COUNT_W-1:0]              section_count_ff;
   logic                                     rsp_valid_ff;
   logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]  rsp_sample_ff;
   logic                                     rsp_clipped_ff;

   logic                                     accept;
   logic                                     coef_wr_en;
   logic [bqf_pkg::COEF_ADDR_W-1:0]          coef_wr_addr;
   logic [bqf_pkg::COEF_ADDR_W-1:0]          coef_rd_addr;
   logic signed [bqf_pkg::COEF_WIDTH-1:0]    coef_rd_data;
   bqf_pkg::bqf_dly_req_type                 dly_req;
   bqf_pkg::bqf_delay_pair_type              dly_rd_data;
   bqf_pkg::bqf_start_type                   start;
   bqf_pkg::bqf_result_type                  result;
   logic                                     eng_idle;
   logic                                     out_free;
   logic [bqf_pkg::SECT_W-1:0]               last_sect;

   assign req_ready = eng_idle;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // drop loads with an out-of-range section or slot
   assign coef_wr_en = accept && (req_operation == bqf_pkg::OP_LOAD)
                       && (int'(req_coef_slot) < bqf_pkg::SLOTS)
                       && (int'(req_coef_section) < bqf_pkg::MAX_SECTIONS);
   assign coef_wr_addr = bqf_pkg::coef_addr(req_coef_section, req_coef_slot);

   always_comb begin
      if (section_count_ff == '0) begin
         last_sect = '0;
      end else if (int'(section_count_ff) > bqf_pkg::MAX_SECTIONS) begin
         last_sect = bqf_pkg::SECT_W'(bqf_pkg::MAX_SECTIONS - 1);
      end else begin
         last_sect = bqf_pkg::SECT_W'(section_count_ff - 1'b1);
      end
   end

   assign start.start     = accept && (req_operation == bqf_pkg::OP_FILTER);
   assign start.last_sect = last_sect;

   bqf_coef_mem u_coef_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (coef_wr_en),
      .wr_addr (coef_wr_addr),
      .wr_data (req_coef_value),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rd_data)
   );

   bqf_delay_mem u_delay_mem (
      .clock   (clock),
      .reset   (reset),
      .req     (dly_req),
      .rd_data (dly_rd_data)
   );

   bqf_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .start_sample (req_sample_in),
      .out_free     (out_free),
      .idle         (eng_idle),
      .result       (result),
      .coef_rd_addr (coef_rd_addr),
      .coef_rd_data (coef_rd_data),
      .dly_req      (dly_req),
      .dly_rd_data  (dly_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         section_count_ff <= bqf_pkg::COUNT_W'(1);
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            section_count_ff <= csr_write_data;
         end
         if (result.valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // hold the result until the next one is captured
      if (result.valid) begin
         rsp_sample_ff  <= result.sample;
         rsp_clipped_ff <= result.clip;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

endmodule
